// ===== rtl/kvlt_pkg.sv =====
// Shared constants, types and helper functions of the key/value line tokenizer.
package kvlt_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int INT_W       = 32;
    localparam int WORD_COUNT  = 8;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ROLE_SKIP  = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    // Lengths of the accepted words: true, y, yes, 1, false, n, no, 0.
    localparam logic [2:0] WORD_LEN [WORD_COUNT] =
        '{3'd4, 3'd1, 3'd3, 3'd1, 3'd5, 3'd1, 3'd2, 3'd1};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } kvlt_item_t;

    typedef struct packed {
        logic [1:0]           byte_role;
        logic                 pair_done;
        logic                 key_dropped;
        logic [LEN_OUT_W-1:0] key_length;
        logic [LEN_OUT_W-1:0] value_length;
        logic [INT_W-1:0]     dec_value;
        logic                 int_ok;
        logic                 int_store;
        logic                 bool_ok;
        logic                 truth_value;
    } kvlt_result_t;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        logic [LENGTH_BITS-1:0] r;
        r = (v == LEN_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    // Character at position pos of accepted word idx; zero past the word's end.
    function automatic logic [7:0] word_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [39:0] text;
        logic [7:0]  c;
        case (idx)
            3'd0:    text = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
            3'd1:    text = {8'h79, 8'h00, 8'h00, 8'h00, 8'h00};
            3'd2:    text = {8'h79, 8'h65, 8'h73, 8'h00, 8'h00};
            3'd3:    text = {8'h31, 8'h00, 8'h00, 8'h00, 8'h00};
            3'd4:    text = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
            3'd5:    text = {8'h6E, 8'h00, 8'h00, 8'h00, 8'h00};
            3'd6:    text = {8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00};
            default: text = {8'h30, 8'h00, 8'h00, 8'h00, 8'h00};
        endcase
        case (pos)
            3'd0:    c = text[39:32];
            3'd1:    c = text[31:24];
            3'd2:    c = text[23:16];
            3'd3:    c = text[15:8];
            3'd4:    c = text[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/kvlt_if.sv =====
// Valid/ready channel interfaces for line bytes and tokenizer results.
interface kvlt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       final_byte;

    modport source (output valid, output char_byte, output final_byte, input ready);
    modport sink   (input valid, input char_byte, input final_byte, output ready);
endinterface

interface kvlt_result_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        byte_role;
    logic                              pair_done;
    logic                              key_dropped;
    logic [kvlt_pkg::LEN_OUT_W-1:0]    key_length;
    logic [kvlt_pkg::LEN_OUT_W-1:0]    value_length;
    logic signed [kvlt_pkg::INT_W-1:0] dec_value;
    logic                              int_ok;
    logic                              int_store;
    logic                              bool_ok;
    logic                              truth_value;

    modport source (output valid, output byte_role, output pair_done, output key_dropped,
                    output key_length, output value_length, output dec_value,
                    output int_ok, output int_store, output bool_ok, output truth_value,
                    input ready);
    modport sink   (input valid, input byte_role, input pair_done, input key_dropped,
                    input key_length, input value_length, input dec_value,
                    input int_ok, input int_store, input bool_ok, input truth_value,
                    output ready);
endinterface

// ===== rtl/kvlt_in_stage.sv =====
// Input register that captures one line byte per word.
module kvlt_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    kvlt_byte_if.sink           byte_ch,
    input  logic                step,
    output logic                item_valid,
    output kvlt_pkg::kvlt_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    kvlt_pkg::kvlt_item_t item_reg;
    logic                 take;

    // The register can be refilled in the same cycle that its word moves on.
    assign byte_ch.ready = !valid_reg || step;
    assign take          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_byte  <= byte_ch.char_byte;
            item_reg.final_byte <= byte_ch.final_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/kvlt_parse_core.sv =====
// Parser state and the per-byte tokenizing, decimal and word-match logic.
module kvlt_parse_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  kvlt_pkg::kvlt_item_t   item,
    output kvlt_pkg::kvlt_result_t result
);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_KEY     = 3'd1,
        MODE_PRE_EQ  = 3'd2,
        MODE_PRE_VAL = 3'd3,
        MODE_VAL_Q   = 3'd4,
        MODE_VAL_U   = 3'd5
    } mode_t;

    mode_t                            mode_reg;
    mode_t                            mode_next;
    logic [kvlt_pkg::LENGTH_BITS-1:0] key_count_reg;
    logic [kvlt_pkg::LENGTH_BITS-1:0] key_count_next;
    logic [kvlt_pkg::LENGTH_BITS-1:0] value_count_reg;
    logic [kvlt_pkg::LENGTH_BITS-1:0] value_count_next;
    logic [kvlt_pkg::INT_W-1:0]       acc_reg;
    logic [kvlt_pkg::INT_W-1:0]       acc_next;
    logic                             minus_reg;
    logic                             minus_next;
    logic                             digits_valid_reg;
    logic                             digits_valid_next;
    logic [kvlt_pkg::WORD_COUNT-1:0]  word_flags_reg;
    logic [kvlt_pkg::WORD_COUNT-1:0]  word_flags_next;

    logic [7:0] c;
    logic       blank;
    logic       space;
    logic       is_digit;
    logic [1:0] role;
    logic       pair;
    logic       drop;
    logic       start_value;
    logic       take_value;

    assign c        = item.char_byte;
    assign blank    = (c == kvlt_pkg::CH_SPACE) || (c == kvlt_pkg::CH_TAB);
    assign space    = blank || (c == kvlt_pkg::CH_NL);
    assign is_digit = (c >= kvlt_pkg::CH_ZERO) && (c <= kvlt_pkg::CH_NINE);

    always_comb
    begin
        mode_next      = mode_reg;
        key_count_next = key_count_reg;
        role           = kvlt_pkg::ROLE_SKIP;
        pair           = 1'b0;
        drop           = 1'b0;
        start_value    = 1'b0;
        take_value     = 1'b0;
        unique case (mode_reg)
            MODE_KEY:
            begin
                if (c == kvlt_pkg::CH_EQ)
                begin
                    mode_next = MODE_PRE_VAL;
                end
                else if (blank)
                begin
                    mode_next = MODE_PRE_EQ;
                end
                else if (c == kvlt_pkg::CH_NL)
                begin
                    drop      = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    role           = kvlt_pkg::ROLE_KEY;
                    key_count_next = kvlt_pkg::sat_inc(key_count_reg);
                end
            end
            MODE_PRE_EQ:
            begin
                if (c == kvlt_pkg::CH_EQ)
                begin
                    mode_next = MODE_PRE_VAL;
                end
                else if (!blank)
                begin
                    drop = 1'b1;
                    if (c == kvlt_pkg::CH_NL)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        role           = kvlt_pkg::ROLE_KEY;
                        key_count_next = kvlt_pkg::LENGTH_BITS'(1);
                        mode_next      = MODE_KEY;
                    end
                end
            end
            MODE_PRE_VAL:
            begin
                if (!blank)
                begin
                    start_value = 1'b1;
                    if (c == kvlt_pkg::CH_QUOTE)
                    begin
                        mode_next = MODE_VAL_Q;
                    end
                    else if (c == kvlt_pkg::CH_NL)
                    begin
                        pair      = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        role       = kvlt_pkg::ROLE_VALUE;
                        take_value = 1'b1;
                        mode_next  = MODE_VAL_U;
                    end
                end
            end
            MODE_VAL_Q:
            begin
                if (c == kvlt_pkg::CH_QUOTE)
                begin
                    pair      = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    role       = kvlt_pkg::ROLE_VALUE;
                    take_value = 1'b1;
                end
            end
            MODE_VAL_U:
            begin
                if (space)
                begin
                    pair      = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    role       = kvlt_pkg::ROLE_VALUE;
                    take_value = 1'b1;
                end
            end
            default:
            begin
                if (space)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == kvlt_pkg::CH_EQ)
                begin
                    key_count_next = '0;
                    mode_next      = MODE_PRE_VAL;
                end
                else
                begin
                    role           = kvlt_pkg::ROLE_KEY;
                    key_count_next = kvlt_pkg::LENGTH_BITS'(1);
                    mode_next      = MODE_KEY;
                end
            end
        endcase

        // The end of the line closes whatever is open.
        if (item.final_byte)
        begin
            if (mode_next == MODE_KEY || mode_next == MODE_PRE_EQ || mode_next == MODE_PRE_VAL)
            begin
                drop = 1'b1;
            end
            else if (mode_next == MODE_VAL_Q || mode_next == MODE_VAL_U)
            begin
                pair = 1'b1;
            end
            mode_next = MODE_IDLE;
        end
    end

    always_comb
    begin
        logic [kvlt_pkg::LENGTH_BITS-1:0] cnt;
        logic [kvlt_pkg::INT_W-1:0]       acc;
        logic                             minus;
        logic                             dv;
        logic [kvlt_pkg::WORD_COUNT-1:0]  flags;

        if (start_value)
        begin
            cnt   = '0;
            acc   = '0;
            minus = 1'b0;
            dv    = 1'b1;
            flags = '1;
        end
        else
        begin
            cnt   = value_count_reg;
            acc   = acc_reg;
            minus = minus_reg;
            dv    = digits_valid_reg;
            flags = word_flags_reg;
        end

        if (take_value)
        begin
            if (is_digit)
            begin
                acc = (acc << 3) + (acc << 1) + {{(kvlt_pkg::INT_W-4){1'b0}}, c[3:0]};
            end
            else if (cnt == '0 && c == kvlt_pkg::CH_MINUS)
            begin
                minus = 1'b1;
            end
            else
            begin
                dv = 1'b0;
            end
            for (int i = 0; i < kvlt_pkg::WORD_COUNT; i++)
            begin
                if (!(cnt < kvlt_pkg::LENGTH_BITS'(kvlt_pkg::WORD_LEN[i]) &&
                      kvlt_pkg::word_char(3'(i), cnt[2:0]) == c))
                begin
                    flags[i] = 1'b0;
                end
            end
            cnt = kvlt_pkg::sat_inc(cnt);
        end

        value_count_next  = cnt;
        acc_next          = acc;
        minus_next        = minus;
        digits_valid_next = dv;
        word_flags_next   = flags;
    end

    always_comb
    begin
        logic [kvlt_pkg::WORD_COUNT-1:0] hit;
        logic [kvlt_pkg::INT_W-1:0]      signed_val;

        for (int i = 0; i < kvlt_pkg::WORD_COUNT; i++)
        begin
            hit[i] = word_flags_next[i] &&
                     (value_count_next == kvlt_pkg::LENGTH_BITS'(kvlt_pkg::WORD_LEN[i]));
        end
        signed_val = minus_next ? (~acc_next + 1'b1) : acc_next;

        result             = '0;
        result.byte_role   = role;
        result.pair_done   = pair;
        result.key_dropped = drop;
        if (pair)
        begin
            result.key_length   = kvlt_pkg::LEN_OUT_W'(key_count_next);
            result.value_length = kvlt_pkg::LEN_OUT_W'(value_count_next);
            result.dec_value    = digits_valid_next ? signed_val : '0;
            result.int_ok       = digits_valid_next;
            result.int_store    = digits_valid_next && (value_count_next != '0);
            result.bool_ok      = |hit;
            result.truth_value  = |hit[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            key_count_reg    <= '0;
            value_count_reg  <= '0;
            acc_reg          <= '0;
            minus_reg        <= 1'b0;
            digits_valid_reg <= 1'b1;
            word_flags_reg   <= '1;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            key_count_reg    <= key_count_next;
            value_count_reg  <= value_count_next;
            acc_reg          <= acc_next;
            minus_reg        <= minus_next;
            digits_valid_reg <= digits_valid_next;
            word_flags_reg   <= word_flags_next;
        end
    end

endmodule

// ===== rtl/kvlt_out_stage.sv =====
// Result register that holds one tokenizer result word until it is taken.
module kvlt_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  kvlt_pkg::kvlt_result_t result,
    output logic                   free,
    kvlt_result_if.source          result_ch
);

    logic                   valid_reg;
    logic                   valid_next;
    kvlt_pkg::kvlt_result_t result_reg;

    assign free = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign result_ch.valid        = valid_reg;
    assign result_ch.byte_role    = result_reg.byte_role;
    assign result_ch.pair_done    = result_reg.pair_done;
    assign result_ch.key_dropped  = result_reg.key_dropped;
    assign result_ch.key_length   = result_reg.key_length;
    assign result_ch.value_length = result_reg.value_length;
    assign result_ch.dec_value    = $signed(result_reg.dec_value);
    assign result_ch.int_ok       = result_reg.int_ok;
    assign result_ch.int_store    = result_reg.int_store;
    assign result_ch.bool_ok      = result_reg.bool_ok;
    assign result_ch.truth_value  = result_reg.truth_value;

endmodule

// ===== rtl/key_value_line_tokenizer_core.sv =====
// Key/value line tokenizer: input register, parser logic and result register.
// A result word is loaded into the result register as its byte word leaves
// the input register; one byte word per cycle while results are taken, and
// the parser state updates once per byte word. Reset (rst_n low) empties both
// registers and returns the parser to idle with cleared counters and value readings.
module key_value_line_tokenizer_core (
    input  logic          clk,
    input  logic          rst_n,
    kvlt_byte_if.sink     byte_ch,
    kvlt_result_if.source result_ch
);

    logic                   item_valid;
    kvlt_pkg::kvlt_item_t   item;
    kvlt_pkg::kvlt_result_t result;
    logic                   out_free;
    logic                   step;

    assign step = item_valid && out_free;

    kvlt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    kvlt_parse_core u_parse_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    kvlt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result    (result),
        .free      (out_free),
        .result_ch (result_ch)
    );

endmodule
